// ===== hdl/c8ic_pkg.sv =====
// c8ic_pkg: request and result types, action and fault codes, register indexes
// and parameter defaults for the chip8 instruction core
// no dependencies
package c8ic_pkg;

    localparam int STACK_DEPTH_DEF   = 16;
    localparam int RAM_BYTES_DEF     = 4096;
    localparam int SCREEN_WIDTH_DEF  = 64;
    localparam int SCREEN_HEIGHT_DEF = 32;

    localparam logic [11:0] START_ADDRESS_RST = 12'd512;
    localparam logic [11:0] FONT_BASE_RST     = 12'd80;

    localparam logic [2:0] ACT_EXECUTE    = 3'd0;
    localparam logic [2:0] ACT_TICK       = 3'd1;
    localparam logic [2:0] ACT_WRITE_BYTE = 3'd2;
    localparam logic [2:0] ACT_READ_ROW   = 3'd3;
    localparam logic [2:0] ACT_READ_BYTE  = 3'd4;

    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_INVALID   = 2'd1;
    localparam logic [1:0] FAULT_OVERFLOW  = 2'd2;
    localparam logic [1:0] FAULT_UNDERFLOW = 2'd3;

    localparam logic REG_START_ADDRESS = 1'b0;
    localparam logic REG_FONT_BASE     = 1'b1;

    typedef struct packed {
        logic [2:0]  action;
        logic [11:0] address;
        logic [7:0]  data_byte;
        logic [15:0] key_mask;
        logic [7:0]  random_byte;
    } t_in_item;

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] opcode;
        logic [1:0]  fault;
        logic        halted;
        logic        waiting_key;
        logic        display_changed;
        logic        sound_on;
        logic [63:0] row_bits;
        logic [7:0]  read_data;
    } t_out_item;

endpackage

// ===== hdl/c8ic_ram.sv =====
// c8ic_ram: generic single write port, single read port ram with registered read
// no dependencies
module c8ic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/chip8_instruction_core.sv =====
// chip8_instruction_core: chip8 interpreter core with program ram, registers,
// call stack, timers and framebuffer, run by a small sequencer
// depends on c8ic_pkg and c8ic_ram
//
// One request is taken at a time; ready is high only while the sequencer is idle.
// Timer tick, ram write and unknown actions go from the start state to the result,
// ram and row reads pass a read state. A plain instruction fetches two bytes and
// then vx and vy through the single read ports, then executes; flag-setting alu ops
// then write vf, and returns load the pc from the stack. A sprite draw wraps the
// origin by repeated subtraction, then reads and writes each drawn row and writes
// the flag; fx33 forms its digits by repeated subtraction, fx55 and fx65 step once
// per register. The result sits in an output register, so the next request may be
// taken while it waits. No clearing pass after reset.
module chip8_instruction_core #(
    parameter int STACK_DEPTH   = c8ic_pkg::STACK_DEPTH_DEF,
    parameter int RAM_BYTES     = c8ic_pkg::RAM_BYTES_DEF,
    parameter int SCREEN_WIDTH  = c8ic_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = c8ic_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  c8ic_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output c8ic_pkg::t_out_item  o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import c8ic_pkg::*;

    localparam int AW  = $clog2(RAM_BYTES);
    localparam int HW  = $clog2(SCREEN_HEIGHT);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int SLW = $clog2(STACK_DEPTH + 1);
    localparam logic [63:0] COL_CLIP = ~(64'hFFFF_FFFF_FFFF_FFFF >> SCREEN_WIDTH);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_F1, S_F2, S_F3, S_F4, S_EX, S_WF, S_RET,
        S_DMX, S_DMY, S_DR0, S_DR1, S_B100, S_B10, S_B1, S_ST, S_ST1,
        S_LD0, S_LD1, S_RR, S_RB, S_DONE
    } t_state;

    function automatic logic [AW-1:0] f_ram_addr(input logic [11:0] a);
        logic [12:0] v;
        v = {1'b0, a};
        for (int s = 0; s < 8; s++) begin
            if (v >= 13'(RAM_BYTES)) begin
                v = v - 13'(RAM_BYTES);
            end
        end
        return v[AW-1:0];
    endfunction

    t_state              r_state;
    logic [11:0]         r_start;
    logic [11:0]         r_font;
    logic [11:0]         r_pc;
    logic [11:0]         r_i;
    logic [SLW-1:0]      r_sp;
    logic [7:0]          r_dt;
    logic [7:0]          r_st;
    logic                r_halt;
    logic [15:0]         r_vvalid;
    logic [SCREEN_HEIGHT-1:0] r_rowvalid;
    logic [SCREEN_HEIGHT-1:0] r_rownz;
    logic                r_vrd_ok;
    logic                r_frd_ok;
    logic                r_ovalid;
    t_out_item           r_out;

    logic [2:0]          r_act;
    logic [11:0]         r_addr;
    logic [7:0]          r_data;
    logic [15:0]         r_keys;
    logic [7:0]          r_rnd;
    logic [15:0]         r_op;
    logic [7:0]          r_vx;
    logic [7:0]          r_vy;
    logic [3:0]          r_cnt;
    logic [7:0]          r_acc;
    logic                r_flag;
    logic                r_hit;
    logic [1:0]          r_fault;
    logic                r_wait;
    logic                r_chg;
    logic [63:0]         r_row;
    logic [7:0]          r_rdata;

    // memory ports
    logic                m_we;
    logic [AW-1:0]       m_waddr;
    logic [7:0]          m_wdata;
    logic [AW-1:0]       m_raddr;
    logic [7:0]          m_rdata;
    logic                v_we;
    logic [3:0]          v_waddr;
    logic [7:0]          v_wdata;
    logic [3:0]          v_raddr;
    logic [7:0]          v_rdata;
    logic                f_we;
    logic [HW-1:0]       f_waddr;
    logic [63:0]         f_wdata;
    logic [HW-1:0]       f_raddr;
    logic                f_rd_in;
    logic [63:0]         f_rdata;
    logic                s_we;
    logic [SW-1:0]       s_waddr;
    logic [SW-1:0]       s_raddr;
    logic [11:0]         s_rdata;

    logic [7:0]          vreg_rd;
    logic [63:0]         row_rd;
    logic [7:0]          nn;
    logic [11:0]         nnn;
    logic [7:0]          alu_res;
    logic                alu_flag;
    logic                alu_bad;
    logic                alu_flagged;
    logic [3:0]          key_idx;
    logic                key_found;
    logic                key_held;
    logic [6:0]          ysum;
    logic                draw_end;
    logic [63:0]         spr_mask;
    logic [12:0]         i_sum;
    logic                stack_full;
    logic                cfg_wr;

    assign nn       = r_op[7:0];
    assign nnn      = r_op[11:0];
    assign vreg_rd  = r_vrd_ok ? v_rdata : 8'd0;
    assign row_rd   = r_frd_ok ? f_rdata : 64'd0;
    assign ysum     = {1'b0, r_vy[5:0]} + {3'b000, r_cnt};
    assign draw_end = (r_cnt == r_op[3:0]) || (ysum >= 7'(SCREEN_HEIGHT));
    assign spr_mask = ({m_rdata, 56'd0} >> r_vx[5:0]) & COL_CLIP;
    assign i_sum    = {1'b0, r_i} + {5'd0, r_vx};
    assign stack_full = (r_sp == SLW'(STACK_DEPTH));
    assign key_held = r_keys[r_vx[3:0]];
    assign cfg_wr   = psel && penable && pwrite;

    always_comb begin
        alu_res     = r_vy;
        alu_flag    = 1'b0;
        alu_bad     = 1'b0;
        alu_flagged = 1'b0;
        unique case (r_op[3:0])
            4'h0: alu_res = r_vy;
            4'h1: alu_res = r_vx | r_vy;
            4'h2: alu_res = r_vx & r_vy;
            4'h3: alu_res = r_vx ^ r_vy;
            4'h4: begin
                {alu_flag, alu_res} = {1'b0, r_vx} + {1'b0, r_vy};
                alu_flagged = 1'b1;
            end
            4'h5: begin
                alu_res = r_vx - r_vy;
                alu_flag = (r_vx >= r_vy);
                alu_flagged = 1'b1;
            end
            4'h6: begin
                alu_res = {1'b0, r_vx[7:1]};
                alu_flag = r_vx[0];
                alu_flagged = 1'b1;
            end
            4'h7: begin
                alu_res = r_vy - r_vx;
                alu_flag = (r_vy >= r_vx);
                alu_flagged = 1'b1;
            end
            4'hE: begin
                alu_res = {r_vx[6:0], 1'b0};
                alu_flag = r_vx[7];
                alu_flagged = 1'b1;
            end
            default: alu_bad = 1'b1;
        endcase
    end

    // lowest held key
    always_comb begin
        key_idx = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) begin
                key_idx = 4'(k);
            end
        end
        key_found = |r_keys;
    end

    always_comb begin
        m_we    = 1'b0;
        m_waddr = f_ram_addr(r_addr);
        m_wdata = r_data;
        m_raddr = f_ram_addr(r_pc);
        v_we    = 1'b0;
        v_waddr = r_op[11:8];
        v_wdata = alu_res;
        v_raddr = r_op[11:8];
        f_we    = 1'b0;
        f_waddr = ysum[HW-1:0];
        f_wdata = row_rd ^ spr_mask;
        f_raddr = '0;
        f_rd_in = 1'b0;
        s_we    = 1'b0;
        s_waddr = r_sp[SW-1:0];
        s_raddr = SW'(r_sp - SLW'(1));
        unique case (r_state)
            S_START: begin
                if (r_act == ACT_READ_BYTE) begin
                    m_raddr = f_ram_addr(r_addr);
                end
                if (r_act == ACT_WRITE_BYTE) begin
                    m_we = 1'b1;
                end
                if (r_addr < 12'(SCREEN_HEIGHT)) begin
                    f_raddr = r_addr[HW-1:0];
                    f_rd_in = 1'b1;
                end
            end
            S_F1: m_raddr = f_ram_addr(r_pc + 12'd1);
            S_F2: v_raddr = r_op[11:8];
            S_F3: v_raddr = r_op[7:4];
            S_EX: begin
                unique case (r_op[15:12])
                    4'h2: s_we = !stack_full;
                    4'h6: begin
                        v_we = 1'b1;
                        v_wdata = nn;
                    end
                    4'h7: begin
                        v_we = 1'b1;
                        v_wdata = r_vx + nn;
                    end
                    4'h8: v_we = !alu_bad;
                    4'hC: begin
                        v_we = 1'b1;
                        v_wdata = r_rnd & nn;
                    end
                    4'hF: begin
                        if (nn == 8'h07) begin
                            v_we = 1'b1;
                            v_wdata = r_dt;
                        end else if (nn == 8'h0A) begin
                            v_we = key_found;
                            v_wdata = {4'd0, key_idx};
                        end
                    end
                    default: ;
                endcase
            end
            S_WF: begin
                v_we = 1'b1;
                v_waddr = 4'hF;
                v_wdata = {7'd0, r_flag};
            end
            S_DR0: begin
                m_raddr = f_ram_addr(r_i + {8'd0, r_cnt});
                if (draw_end) begin
                    v_we = 1'b1;
                    v_waddr = 4'hF;
                    v_wdata = {7'd0, r_hit};
                end else begin
                    f_raddr = ysum[HW-1:0];
                    f_rd_in = 1'b1;
                end
            end
            S_DR1: f_we = 1'b1;
            S_B100: begin
                m_waddr = f_ram_addr(r_i);
                m_wdata = {4'd0, r_cnt};
                m_we = (r_acc < 8'd100);
            end
            S_B10: begin
                m_waddr = f_ram_addr(r_i + 12'd1);
                m_wdata = {4'd0, r_cnt};
                m_we = (r_acc < 8'd10);
            end
            S_B1: begin
                m_waddr = f_ram_addr(r_i + 12'd2);
                m_wdata = r_acc;
                m_we = 1'b1;
            end
            S_ST: v_raddr = r_cnt;
            S_ST1: begin
                m_waddr = f_ram_addr(r_i + {8'd0, r_cnt});
                m_wdata = vreg_rd;
                m_we = 1'b1;
            end
            S_LD0: m_raddr = f_ram_addr(r_i + {8'd0, r_cnt});
            S_LD1: begin
                v_we = 1'b1;
                v_waddr = r_cnt;
                v_wdata = m_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_start    <= START_ADDRESS_RST;
            r_font     <= FONT_BASE_RST;
            r_pc       <= START_ADDRESS_RST;
            r_i        <= 12'd0;
            r_sp       <= '0;
            r_dt       <= 8'd0;
            r_st       <= 8'd0;
            r_halt     <= 1'b0;
            r_vvalid   <= '0;
            r_rowvalid <= '0;
            r_rownz    <= '0;
            r_ovalid   <= 1'b0;
            r_vrd_ok   <= 1'b0;
            r_frd_ok   <= 1'b0;
        end else begin
            r_vrd_ok <= r_vvalid[v_raddr];
            r_frd_ok <= f_rd_in && r_rowvalid[f_raddr];
            if (v_we) begin
                r_vvalid[v_waddr] <= 1'b1;
            end
            if (f_we) begin
                r_rowvalid[f_waddr] <= 1'b1;
                r_rownz[f_waddr]    <= |f_wdata;
            end
            if (r_state == S_DONE && (!r_ovalid || i_out_ready)) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act   <= i_in_data.action;
                        r_addr  <= i_in_data.address;
                        r_data  <= i_in_data.data_byte;
                        r_keys  <= i_in_data.key_mask;
                        r_rnd   <= i_in_data.random_byte;
                        r_op    <= 16'd0;
                        r_fault <= FAULT_NONE;
                        r_wait  <= 1'b0;
                        r_chg   <= 1'b0;
                        r_row   <= 64'd0;
                        r_rdata <= 8'd0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    priority if (r_act == ACT_EXECUTE) begin
                        r_state <= r_halt ? S_DONE : S_F1;
                    end else if (r_act == ACT_TICK) begin
                        if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                        if (r_st != 8'd0) r_st <= r_st - 8'd1;
                        r_state <= S_DONE;
                    end else if (r_act == ACT_READ_ROW) begin
                        r_state <= S_RR;
                    end else if (r_act == ACT_READ_BYTE) begin
                        r_state <= S_RB;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_F1: begin
                    r_op[15:8] <= m_rdata;
                    r_state <= S_F2;
                end
                S_F2: begin
                    r_op[7:0] <= m_rdata;
                    r_state <= S_F3;
                end
                S_F3: begin
                    r_vx <= vreg_rd;
                    if (r_op == 16'd0) begin
                        r_halt  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_pc    <= r_pc + 12'd2;
                        r_state <= S_F4;
                    end
                end
                S_F4: begin
                    r_vy <= vreg_rd;
                    r_state <= S_EX;
                end
                S_EX: begin
                    r_state <= S_DONE;
                    unique case (r_op[15:12])
                        4'h0: begin
                            if (r_op == 16'h00E0) begin
                                r_chg      <= |r_rownz;
                                r_rowvalid <= '0;
                                r_rownz    <= '0;
                            end else if (r_op == 16'h00EE) begin
                                if (r_sp == '0) begin
                                    r_fault <= FAULT_UNDERFLOW;
                                end else begin
                                    r_sp    <= r_sp - SLW'(1);
                                    r_state <= S_RET;
                                end
                            end else begin
                                r_fault <= FAULT_INVALID;
                            end
                        end
                        4'h1: r_pc <= nnn;
                        4'h2: begin
                            if (stack_full) begin
                                r_fault <= FAULT_OVERFLOW;
                            end else begin
                                r_sp <= r_sp + SLW'(1);
                                r_pc <= nnn;
                            end
                        end
                        4'h3: if (r_vx == nn) r_pc <= r_pc + 12'd2;
                        4'h4: if (r_vx != nn) r_pc <= r_pc + 12'd2;
                        4'h5: begin
                            if (r_op[3:0] != 4'd0) r_fault <= FAULT_INVALID;
                            else if (r_vx == r_vy) r_pc <= r_pc + 12'd2;
                        end
                        4'h6, 4'h7, 4'hC: ;
                        4'h8: begin
                            r_flag <= alu_flag;
                            if (alu_bad) r_fault <= FAULT_INVALID;
                            else if (alu_flagged) r_state <= S_WF;
                        end
                        4'h9: begin
                            if (r_op[3:0] != 4'd0) r_fault <= FAULT_INVALID;
                            else if (r_vx != r_vy) r_pc <= r_pc + 12'd2;
                        end
                        4'hA: r_i <= nnn;
                        4'hB: r_pc <= nnn + {4'd0, r_vx};
                        4'hD: begin
                            r_cnt   <= 4'd0;
                            r_hit   <= 1'b0;
                            r_state <= S_DMX;
                        end
                        4'hE: begin
                            if (nn == 8'h9E) begin
                                if (key_held) r_pc <= r_pc + 12'd2;
                            end else if (nn == 8'hA1) begin
                                if (!key_held) r_pc <= r_pc + 12'd2;
                            end else begin
                                r_fault <= FAULT_INVALID;
                            end
                        end
                        4'hF: begin
                            unique case (nn)
                                8'h07: ;
                                8'h0A: begin
                                    if (!key_found) begin
                                        r_pc   <= r_pc - 12'd2;
                                        r_wait <= 1'b1;
                                    end
                                end
                                8'h15: r_dt <= r_vx;
                                8'h18: r_st <= r_vx;
                                8'h1E: begin
                                    r_i <= i_sum[11:0];
                                    r_flag <= 1'b1;
                                    if (i_sum[12]) r_state <= S_WF;
                                end
                                8'h29: r_i <= r_font + {6'd0, r_vx[3:0], 2'b00}
                                                     + {8'd0, r_vx[3:0]};
                                8'h33: begin
                                    r_acc   <= r_vx;
                                    r_cnt   <= 4'd0;
                                    r_state <= S_B100;
                                end
                                8'h55: begin
                                    r_cnt   <= 4'd0;
                                    r_state <= S_ST;
                                end
                                8'h65: begin
                                    r_cnt   <= 4'd0;
                                    r_state <= S_LD0;
                                end
                                default: r_fault <= FAULT_INVALID;
                            endcase
                        end
                        default: ;
                    endcase
                end
                S_WF: r_state <= S_DONE;
                S_RET: begin
                    r_pc <= s_rdata;
                    r_state <= S_DONE;
                end
                // wrap of the sprite origin by repeated subtraction
                S_DMX: begin
                    if (r_vx >= 8'(SCREEN_WIDTH)) r_vx <= r_vx - 8'(SCREEN_WIDTH);
                    else r_state <= S_DMY;
                end
                S_DMY: begin
                    if (r_vy >= 8'(SCREEN_HEIGHT)) r_vy <= r_vy - 8'(SCREEN_HEIGHT);
                    else r_state <= S_DR0;
                end
                S_DR0: r_state <= draw_end ? S_DONE : S_DR1;
                S_DR1: begin
                    r_hit <= r_hit | (|(row_rd & spr_mask));
                    r_chg <= r_chg | (|spr_mask);
                    r_cnt <= r_cnt + 4'd1;
                    r_state <= S_DR0;
                end
                S_B100: begin
                    if (r_acc >= 8'd100) begin
                        r_acc <= r_acc - 8'd100;
                        r_cnt <= r_cnt + 4'd1;
                    end else begin
                        r_cnt <= 4'd0;
                        r_state <= S_B10;
                    end
                end
                S_B10: begin
                    if (r_acc >= 8'd10) begin
                        r_acc <= r_acc - 8'd10;
                        r_cnt <= r_cnt + 4'd1;
                    end else begin
                        r_state <= S_B1;
                    end
                end
                S_B1: r_state <= S_DONE;
                S_ST: r_state <= S_ST1;
                S_ST1: begin
                    r_cnt <= r_cnt + 4'd1;
                    r_state <= (r_cnt == r_op[11:8]) ? S_DONE : S_ST;
                end
                S_LD0: r_state <= S_LD1;
                S_LD1: begin
                    r_cnt <= r_cnt + 4'd1;
                    r_state <= (r_cnt == r_op[11:8]) ? S_DONE : S_LD0;
                end
                S_RR: begin
                    r_row <= row_rd;
                    r_state <= S_DONE;
                end
                S_RB: begin
                    r_rdata <= m_rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_out.pc              <= r_pc;
                        r_out.opcode          <= r_op;
                        r_out.fault           <= r_fault;
                        r_out.halted          <= r_halt;
                        r_out.waiting_key     <= r_wait;
                        r_out.display_changed <= r_chg;
                        r_out.sound_on        <= (r_st != 8'd0);
                        r_out.row_bits        <= r_row;
                        r_out.read_data       <= r_rdata;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (cfg_wr) begin
                if (paddr[2] == REG_START_ADDRESS) begin
                    r_start <= pwdata[11:0];
                    r_pc    <= pwdata[11:0];
                end else begin
                    r_font <= pwdata[11:0];
                end
            end
        end
    end

    c8ic_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_prog_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    c8ic_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    c8ic_ram #(.WIDTH(64), .DEPTH(SCREEN_HEIGHT)) u_frame (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    c8ic_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (r_pc),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign prdata      = (paddr[2] == REG_FONT_BASE) ? {20'd0, r_font} : {20'd0, r_start};
    assign pready      = 1'b1;
endmodule

// ===== verif/c8ic_checker.sv =====
// c8ic_checker: watches the request, result and register ports of the chip8 core,
// keeps its own copy of the core state and checks each result in order
// depends on c8ic_pkg
`timescale 1ns / 100ps

module c8ic_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  c8ic_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  c8ic_pkg::t_out_item i_out_data,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output int                  o_errors,
    output int                  o_pending
);
    import c8ic_pkg::*;

    logic [7:0]  mem [4096];
    logic [63:0] scr [SCREEN_HEIGHT_DEF];
    logic [7:0]  vreg [16];
    logic [11:0] call_ret [STACK_DEPTH_DEF];
    logic [11:0] idx_reg, pc_reg, start_addr, font_addr;
    logic [7:0]  delay_cnt, sound_cnt;
    int          depth;
    bit          halt;
    t_out_item   expected_results [$];

    function automatic logic [1:0] run_opcode(input logic [15:0] op, input logic [15:0] keys,
                                              input logic [7:0] rnd, inout bit chg,
                                              inout bit wt);
        logic [3:0]  x, y, n;
        logic [7:0]  nn, vx, vy, bits;
        logic [11:0] nnn, a;
        logic [8:0]  sum;
        logic [12:0] wide;
        int          x0, y0, row, col;
        bit          hit;
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        nn = op[7:0];
        nnn = op[11:0];
        vx = vreg[x];
        vy = vreg[y];
        case (op[15:12])
            4'h0: begin
                if (op == 16'h00E0) begin
                    for (int r = 0; r < SCREEN_HEIGHT_DEF; r++) begin
                        if (scr[r] != 0) chg = 1;
                        scr[r] = '0;
                    end
                    return FAULT_NONE;
                end
                if (op == 16'h00EE) begin
                    if (depth == 0) return FAULT_UNDERFLOW;
                    depth--;
                    pc_reg = call_ret[depth];
                    return FAULT_NONE;
                end
                return FAULT_INVALID;
            end
            4'h1: pc_reg = nnn;
            4'h2: begin
                if (depth >= STACK_DEPTH_DEF) return FAULT_OVERFLOW;
                call_ret[depth] = pc_reg;
                depth++;
                pc_reg = nnn;
            end
            4'h3: if (vx == nn) pc_reg = pc_reg + 12'd2;
            4'h4: if (vx != nn) pc_reg = pc_reg + 12'd2;
            4'h5: begin
                if (n != 0) return FAULT_INVALID;
                if (vx == vy) pc_reg = pc_reg + 12'd2;
            end
            4'h6: vreg[x] = nn;
            4'h7: vreg[x] = vx + nn;
            4'h8: begin
                case (n)
                    4'h0: vreg[x] = vy;
                    4'h1: vreg[x] = vx | vy;
                    4'h2: vreg[x] = vx & vy;
                    4'h3: vreg[x] = vx ^ vy;
                    4'h4: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        vreg[x] = sum[7:0];
                        vreg[15] = {7'd0, sum[8]};
                    end
                    4'h5: begin
                        vreg[x] = vx - vy;
                        vreg[15] = {7'd0, vx >= vy};
                    end
                    4'h6: begin
                        vreg[x] = vx >> 1;
                        vreg[15] = {7'd0, vx[0]};
                    end
                    4'h7: begin
                        vreg[x] = vy - vx;
                        vreg[15] = {7'd0, vy >= vx};
                    end
                    4'hE: begin
                        vreg[x] = vx << 1;
                        vreg[15] = {7'd0, vx[7]};
                    end
                    default: return FAULT_INVALID;
                endcase
            end
            4'h9: begin
                if (n != 0) return FAULT_INVALID;
                if (vx != vy) pc_reg = pc_reg + 12'd2;
            end
            4'hA: idx_reg = nnn;
            4'hB: pc_reg = nnn + {4'd0, vx};
            4'hC: vreg[x] = rnd & nn;
            4'hD: begin
                x0 = vx % SCREEN_WIDTH_DEF;
                y0 = vy % SCREEN_HEIGHT_DEF;
                hit = 0;
                for (int i = 0; i < n; i++) begin
                    row = y0 + i;
                    if (row >= SCREEN_HEIGHT_DEF) break;
                    a = idx_reg + 12'(i);
                    bits = mem[a];
                    for (int j = 0; j < 8; j++) begin
                        col = x0 + j;
                        if (col >= SCREEN_WIDTH_DEF) break;
                        if (bits[7-j]) begin
                            if (scr[row][63-col]) hit = 1;
                            scr[row][63-col] = ~scr[row][63-col];
                            chg = 1;
                        end
                    end
                end
                vreg[15] = {7'd0, hit};
            end
            4'hE: begin
                if (nn == 8'h9E) begin
                    if (keys[vx[3:0]]) pc_reg = pc_reg + 12'd2;
                end else if (nn == 8'hA1) begin
                    if (!keys[vx[3:0]]) pc_reg = pc_reg + 12'd2;
                end else begin
                    return FAULT_INVALID;
                end
            end
            default: begin
                case (nn)
                    8'h07: vreg[x] = delay_cnt;
                    8'h0A: begin
                        if (keys == 0) begin
                            pc_reg = pc_reg - 12'd2;
                            wt = 1;
                        end else begin
                            for (int k = 15; k >= 0; k--) if (keys[k]) vreg[x] = 8'(k);
                        end
                    end
                    8'h15: delay_cnt = vx;
                    8'h18: sound_cnt = vx;
                    8'h1E: begin
                        wide = {1'b0, idx_reg} + {5'd0, vx};
                        idx_reg = wide[11:0];
                        if (wide[12]) vreg[15] = 8'd1;
                    end
                    8'h29: idx_reg = font_addr + 12'd5 * {8'd0, vx[3:0]};
                    8'h33: begin
                        mem[idx_reg] = vx / 8'd100;
                        mem[idx_reg + 12'd1] = (vx / 8'd10) % 8'd10;
                        mem[idx_reg + 12'd2] = vx % 8'd10;
                    end
                    8'h55: for (int k = 0; k <= x; k++) mem[idx_reg + 12'(k)] = vreg[k];
                    8'h65: for (int k = 0; k <= x; k++) vreg[k] = mem[idx_reg + 12'(k)];
                    default: return FAULT_INVALID;
                endcase
            end
        endcase
        return FAULT_NONE;
    endfunction

    function automatic t_out_item apply_request(input t_in_item req);
        t_out_item res;
        logic [15:0] op;
        bit chg, wt;
        res = '0;
        chg = 0;
        wt = 0;
        case (req.action)
            ACT_EXECUTE: begin
                if (!halt) begin
                    op = {mem[pc_reg], mem[pc_reg + 12'd1]};
                    if (op == 0) begin
                        halt = 1;
                    end else begin
                        res.opcode = op;
                        pc_reg = pc_reg + 12'd2;
                        res.fault = run_opcode(op, req.key_mask, req.random_byte, chg, wt);
                    end
                end
            end
            ACT_TICK: begin
                if (delay_cnt > 0) delay_cnt--;
                if (sound_cnt > 0) sound_cnt--;
            end
            ACT_WRITE_BYTE: mem[req.address] = req.data_byte;
            ACT_READ_ROW: if (req.address < SCREEN_HEIGHT_DEF) res.row_bits = scr[req.address];
            ACT_READ_BYTE: res.read_data = mem[req.address];
            default: ;
        endcase
        res.pc = pc_reg;
        res.halted = halt;
        res.waiting_key = wt;
        res.display_changed = chg;
        res.sound_on = sound_cnt > 0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int r = 0; r < SCREEN_HEIGHT_DEF; r++) scr[r] = '0;
            for (int r = 0; r < 16; r++) vreg[r] = '0;
            start_addr = START_ADDRESS_RST;
            font_addr = FONT_BASE_RST;
            pc_reg = START_ADDRESS_RST;
            idx_reg = '0;
            depth = 0;
            delay_cnt = '0;
            sound_cnt = '0;
            halt = 0;
            expected_results.delete();
            o_errors = 0;
            o_pending = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_START_ADDRESS) begin
                    start_addr = i_pwdata[11:0];
                    pc_reg = i_pwdata[11:0];
                end else begin
                    font_addr = i_pwdata[11:0];
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result %p", i_out_data);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data !== want) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch\n  exp %p\n  got %p", want, i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready) expected_results.push_back(apply_request(i_in_data));
            o_pending = expected_results.size();
        end
    end

endmodule

// ===== verif/tb_chip8_instruction_core.sv =====
// tb_chip8_instruction_core: request stimulus, register writes and verdict for
// the chip8 instruction core, with c8ic_checker beside the block
// depends on c8ic_pkg, chip8_instruction_core and c8ic_checker
`timescale 1ns / 100ps

module tb_chip8_instruction_core;
    import c8ic_pkg::*;

    localparam logic [15:0] OP_CLEAR  = 16'h00E0;
    localparam logic [15:0] OP_RETURN = 16'h00EE;

    logic        i_clk, i_rst_n;
    logic        req_valid, req_ready, res_valid, res_ready;
    t_in_item    req_data;
    t_out_item   res_data;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          errors, pending;
    bit          no_idle;
    logic [11:0] seen_pc;
    int          executed;

    chip8_instruction_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(req_valid), .o_in_ready(req_ready), .i_in_data(req_data),
        .o_out_valid(res_valid), .i_out_ready(res_ready), .o_out_data(res_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    c8ic_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(req_valid), .i_in_ready(req_ready), .i_in_data(req_data),
        .i_out_valid(res_valid), .i_out_ready(res_ready), .i_out_data(res_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        res_ready <= no_idle || ($urandom_range(99) >= 35);
        if (res_valid && res_ready) seen_pc <= res_data.pc;
    end

    task automatic send(input t_in_item req);
        int gap;
        if (!no_idle && $urandom_range(99) < 35) begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_data <= req;
        do @(posedge i_clk); while (!req_ready);
        if (req.action == ACT_EXECUTE) executed++;
    endtask

    function automatic t_in_item make_req(input logic [2:0] act, input logic [11:0] addr,
                                          input logic [7:0] data);
        t_in_item req;
        req.action = act;
        req.address = addr;
        req.data_byte = data;
        req.key_mask = ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom);
        req.random_byte = 8'($urandom);
        return req;
    endfunction

    task automatic run_op(input logic [15:0] keys);
        t_in_item req;
        req = make_req(ACT_EXECUTE, 12'($urandom), 8'($urandom));
        req.key_mask = keys;
        send(req);
    endtask

    task automatic store_word(input logic [11:0] addr, input logic [15:0] word);
        send(make_req(ACT_WRITE_BYTE, addr, word[15:8]));
        send(make_req(ACT_WRITE_BYTE, addr + 12'd1, word[7:0]));
    endtask

    // wait for every outstanding result, then settle the observed pc
    task automatic drain;
        req_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic reg_idx, input logic [11:0] value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= {20'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == REG_START_ADDRESS) begin
            send(make_req(ACT_TICK, 12'd0, 8'd0));
            drain();
        end
    endtask

    function automatic logic [15:0] pick_opcode();
        logic [3:0] x, y, n;
        logic [7:0] nn;
        x = 4'($urandom);
        y = 4'($urandom);
        n = 4'($urandom);
        nn = 8'($urandom);
        case ($urandom_range(24))
            0:  return OP_CLEAR;
            1:  return ($urandom_range(3) == 0) ? OP_RETURN : {4'h1, 12'($urandom_range(12'hEFF))};
            2:  return {4'h2, 12'($urandom_range(12'hEFF))};
            3:  return {4'h3, x, nn};
            4:  return {4'h4, x, nn};
            5:  return {4'h5, x, y, 4'h0};
            6, 7: return {4'h6, x, nn};
            8:  return {4'h7, x, nn};
            9, 10, 11: begin
                n = 4'($urandom_range(8));
                return {4'h8, x, y, (n == 4'd8) ? 4'hE : n};
            end
            12: return {4'h9, x, y, 4'h0};
            13: return {4'hA, 4'hF, nn};
            14: return {4'hB, x, nn};
            15: return {4'hC, x, nn};
            16, 17: return {4'hD, x, y, n};
            18: return {4'hE, x, ($urandom_range(1) == 0) ? 8'h9E : 8'hA1};
            19: return {4'hF, x, ($urandom_range(1) == 0) ? 8'h07 : 8'h0A};
            20: return {4'hF, x, ($urandom_range(1) == 0) ? 8'h15 : 8'h18};
            21: return {4'hF, x, ($urandom_range(1) == 0) ? 8'h1E : 8'h29};
            22: return {4'hF, x, ($urandom_range(2) == 0) ? 8'h33 : 8'h65};
            23: return {4'hF, x, 8'h55};
            default: begin
                case ($urandom_range(4))
                    0: return {4'h0, 4'h1 + 4'($urandom_range(14)), nn};
                    1: return {4'h5, x, y, 4'h1 + 4'($urandom_range(14))};
                    2: return {4'h8, x, y, 4'h8 + 4'($urandom_range(5))};
                    3: return {4'hE, x, 8'h00};
                    default: return {4'hF, x, 8'hFF};
                endcase
            end
        endcase
    endfunction

    task automatic side_request;
        case ($urandom_range(9))
            0, 1, 2: send(make_req(ACT_TICK, 12'($urandom), 8'($urandom)));
            3, 4: send(make_req(ACT_READ_ROW, 12'($urandom_range(40)), 8'($urandom)));
            5: send(make_req(ACT_READ_ROW, 12'($urandom), 8'($urandom)));
            6, 7: send(make_req(ACT_READ_BYTE, 12'($urandom), 8'($urandom)));
            8: send(make_req(ACT_WRITE_BYTE, 12'($urandom), 8'($urandom_range(1, 255))));
            default: send(make_req(ACT_READ_BYTE + 3'd1 + 3'($urandom_range(2)),
                                   12'($urandom), 8'($urandom)));
        endcase
    endtask

    initial begin
        logic [15:0] prog [$];
        logic [11:0] base;
        int len, sel;
        req_valid = 0;
        req_data = '0;
        res_ready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        executed = 0;
        no_idle = 1;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill memory with harmless register loads and adds so nothing is read unwritten
        for (int a = 0; a < 4096; a++)
            send(make_req(ACT_WRITE_BYTE, 12'(a), 8'($urandom_range(8'h60, 8'h7F))));
        no_idle = 0;

        reg_write(REG_FONT_BASE, 12'hFFF);
        reg_write(REG_START_ADDRESS, 12'h300);
        send(make_req(ACT_WRITE_BYTE, 12'hFFF, 8'hFF));
        send(make_req(ACT_READ_BYTE, 12'hFFF, 8'h00));
        send(make_req(ACT_READ_BYTE, 12'h000, 8'h00));
        send(make_req(ACT_READ_ROW, 12'd31, 8'h00));
        send(make_req(ACT_READ_ROW, 12'd32, 8'h00));
        send(make_req(ACT_READ_ROW, 12'hFFF, 8'h00));
        send(make_req(ACT_READ_BYTE + 3'd3, 12'h000, 8'h00));

        prog = '{OP_CLEAR, 16'h6005, 16'h610A, 16'hF029, 16'hD015, 16'hD015, 16'hD120,
                 OP_CLEAR, 16'hF30A, 16'h0123, OP_RETURN, 16'h2316, OP_RETURN};
        foreach (prog[k]) store_word(12'h300 + 12'(2 * k), prog[k]);
        for (int k = 0; k < 8; k++) run_op(16'hFFFF);
        run_op(16'h0000);
        run_op(16'h8000);
        run_op(16'h0000);
        run_op(16'h0000);
        // calls to self fill the stack and then overflow, returns unwind it past empty
        repeat (17) run_op(16'h0000);
        repeat (17) run_op(16'h0000);
        send(make_req(ACT_READ_ROW, 12'd10, 8'h00));

        sel = 0;
        while (executed < 640) begin
            sel++;
            no_idle = (sel >= 20 && sel < 32);
            if ($urandom_range(7) == 0) begin
                case ($urandom_range(3))
                    0: reg_write(REG_START_ADDRESS, 12'h000);
                    1: reg_write(REG_START_ADDRESS, 12'hFFF);
                    default: reg_write(REG_START_ADDRESS, 12'($urandom_range(12'hEFF)));
                endcase
                case ($urandom_range(3))
                    0: reg_write(REG_FONT_BASE, 12'h000);
                    1: reg_write(REG_FONT_BASE, 12'hFFF);
                    default: reg_write(REG_FONT_BASE, 12'($urandom));
                endcase
            end
            drain();
            base = seen_pc;
            len = $urandom_range(4, 12);
            for (int k = 0; k < len; k++) store_word(base + 12'(2 * k), pick_opcode());
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(99) < 30) side_request();
                run_op(($urandom_range(3) == 0) ? 16'h0 : 16'($urandom));
            end
        end

        drain();
        store_word(seen_pc, 16'h0000);
        run_op(16'h0000);
        run_op(16'hFFFF);
        send(make_req(ACT_TICK, 12'd0, 8'd0));
        drain();
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/c8ic_pkg.sv
hdl/c8ic_ram.sv
hdl/chip8_instruction_core.sv
verif/c8ic_checker.sv
verif/tb_chip8_instruction_core.sv
